### rtl/lphm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear probe hash map core.
// No dependencies.
package lphm_pkg;

    localparam int unsigned TEXT_W    = 64;
    localparam int unsigned BYTES     = TEXT_W / 8;
    localparam int unsigned RED_BITS  = 4;
    localparam int unsigned RED_GROUPS = TEXT_W / RED_BITS;
    localparam logic [TEXT_W-1:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_LIVE    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTYVAL = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_REDUCE,
        S_PREP,
        S_PROBE,
        S_RESP
    } state_t;

    typedef struct packed {
        mark_t             mark;
        logic [TEXT_W-1:0] key;
        logic [TEXT_W-1:0] value;
    } slot_t;

endpackage

### rtl/linear_probe_hash_map_core.sv
`timescale 1ns / 1ps
// Linear probing hash map core: FSM, djb2 hasher, modulo reducer, probe logic.
// Depends on lphm_pkg and lphm_ram.
//
// Usage:
//   Request channel: drive mode/key/value and raise start; the item is taken
//   at a clock edge where start is high and busy is low. mode 0 adds key with
//   value, 1 gets the value for key, 2 removes key. Text is up to 8 bytes,
//   first byte low, a NUL byte ends it.
//   Result channel: done pulses for one cycle with status and value_out.
//   There is no backpressure; the receiver must take the result then.
// Sequence:
//   Adds refused up front (full, empty value) and unused modes answer in the
//   cycle after the accept. Otherwise: hashing, one byte per cycle up to the
//   first NUL or the last byte; modulo reduction, 4 hash bits per cycle; a
//   read setup state; then the probe walk, one table read per cycle; then
//   the done cycle. The probe walk over the single-read-port slot RAM
//   dominates the time per item. One item at a time; busy stays high
//   until done has been shown.
// Reset: marks are cleared by a sweep over every slot (one slot per cycle)
//   after reset; busy is high during the sweep. live count resets to zero.
module linear_probe_hash_map_core #(
    parameter int unsigned SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        done,
    output logic [2:0]  status,
    output logic [63:0] value_out
);

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned RW = AW + 1;
    localparam int unsigned LW = $clog2(SLOTS + 1);
    localparam int unsigned SW = $bits(lphm_pkg::slot_t);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [RW-1:0] SLOTS_R   = RW'(SLOTS);
    localparam logic [LW-1:0] SLOTS_L   = LW'(SLOTS);
    localparam logic [3:0]    LAST_GRP  = 4'(lphm_pkg::RED_GROUPS - 1);
    localparam logic [2:0]    LAST_BYTE = 3'(lphm_pkg::BYTES - 1);

    // Zero every byte after the first NUL.
    function automatic logic [63:0] norm_text(input logic [63:0] t);
        logic [63:0] o;
        logic        run;
        o   = '0;
        run = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if (t[8*b +: 8] == 8'd0)
            begin
                run = 1'b0;
            end
            if (run)
            begin
                o[8*b +: 8] = t[8*b +: 8];
            end
        end
        return o;
    endfunction

    lphm_pkg::state_t  state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [63:0]       key_reg, key_next;
    logic [63:0]       val_reg, val_next;
    logic [63:0]       hash_reg, hash_next;
    logic [2:0]        byte_idx_reg, byte_idx_next;
    logic [3:0]        grp_reg, grp_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [LW-1:0]     live_reg, live_next;
    lphm_pkg::status_t status_reg, status_next;
    logic [63:0]       vout_reg, vout_next;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    lphm_pkg::slot_t   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    lphm_pkg::slot_t   ram_rdata;

    // Decode helpers
    logic [63:0]   key_in_n, val_in_n;
    logic          early_resp;
    lphm_pkg::status_t early_status;
    logic [7:0]    cur_byte;
    logic          is_live, key_eq, last_probe, first_probe;
    logic          probe_done;
    logic          is_add;
    logic [AW-1:0] addr_inc;

    lphm_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign key_in_n = norm_text(key);
    assign val_in_n = norm_text(value);

    // Requests answered without touching the table.
    always_comb
    begin
        early_resp   = 1'b0;
        early_status = lphm_pkg::ST_NOTFOUND;
        if (mode == lphm_pkg::MODE_ADD)
        begin
            if (live_reg == SLOTS_L)
            begin
                early_resp   = 1'b1;
                early_status = lphm_pkg::ST_FULL;
            end
            else if (value[7:0] == 8'd0)
            begin
                early_resp   = 1'b1;
                early_status = lphm_pkg::ST_EMPTYVAL;
            end
        end
        else if (mode != lphm_pkg::MODE_GET && mode != lphm_pkg::MODE_REMOVE)
        begin
            early_resp = 1'b1;
        end
    end

    assign cur_byte    = key_reg[{byte_idx_reg, 3'b000} +: 8];
    assign is_add      = (mode_reg == lphm_pkg::MODE_ADD);
    assign is_live     = (ram_rdata.mark == lphm_pkg::MARK_LIVE);
    assign key_eq      = (ram_rdata.key == key_reg);
    assign last_probe  = (cnt_reg == LAST_SLOT);
    assign first_probe = (cnt_reg == '0);
    assign addr_inc    = (addr_reg == LAST_SLOT) ? '0 : addr_reg + AW'(1);

    // Probe finishes: add stops at the first free slot or a duplicate, get/remove
    // on a dead home slot or a live matching key; all stop after the last slot.
    always_comb
    begin
        if (is_add)
        begin
            probe_done = !is_live || key_eq || last_probe;
        end
        else
        begin
            probe_done = (first_probe && !is_live) || (is_live && key_eq) || last_probe;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lphm_pkg::S_CLEAR:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = lphm_pkg::S_IDLE;
                end
            end
            lphm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = early_resp ? lphm_pkg::S_RESP : lphm_pkg::S_HASH;
                end
            end
            lphm_pkg::S_HASH:
            begin
                if (cur_byte == 8'd0 || byte_idx_reg == LAST_BYTE)
                begin
                    state_next = lphm_pkg::S_REDUCE;
                end
            end
            lphm_pkg::S_REDUCE:
            begin
                if (grp_reg == LAST_GRP)
                begin
                    state_next = lphm_pkg::S_PREP;
                end
            end
            lphm_pkg::S_PREP:
            begin
                state_next = lphm_pkg::S_PROBE;
            end
            lphm_pkg::S_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = lphm_pkg::S_RESP;
                end
            end
            lphm_pkg::S_RESP:
            begin
                state_next = lphm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lphm_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and RAM control
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = addr_inc;
        case (state_reg)
            lphm_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
            end
            lphm_pkg::S_IDLE:
            begin
                busy = 1'b0;
            end
            lphm_pkg::S_PREP:
            begin
                ram_raddr = rem_reg[AW-1:0];
            end
            lphm_pkg::S_PROBE:
            begin
                if (is_add && !is_live)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{mark: lphm_pkg::MARK_LIVE, key: key_reg, value: val_reg};
                end
                else if (!is_add && is_live && key_eq && mode_reg == lphm_pkg::MODE_REMOVE)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{mark: lphm_pkg::MARK_DELETED, key: ram_rdata.key,
                                  value: ram_rdata.value};
                end
            end
            lphm_pkg::S_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        logic [RW-1:0] r;
        mode_next     = mode_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        hash_next     = hash_reg;
        byte_idx_next = byte_idx_reg;
        grp_next      = grp_reg;
        rem_next      = rem_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        live_next     = live_reg;
        status_next   = status_reg;
        vout_next     = vout_reg;
        r             = rem_reg;
        case (state_reg)
            lphm_pkg::S_CLEAR:
            begin
                cnt_next = cnt_reg + AW'(1);
            end
            lphm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next     = mode;
                    key_next      = key_in_n;
                    val_next      = val_in_n;
                    hash_next     = lphm_pkg::HASH_SEED;
                    byte_idx_next = '0;
                    grp_next      = '0;
                    rem_next      = '0;
                    status_next   = early_status;
                    vout_next     = '0;
                end
            end
            lphm_pkg::S_HASH:
            begin
                // djb2: h * 33 + sign-extended byte
                if (cur_byte != 8'd0)
                begin
                    hash_next = (hash_reg << 5) + hash_reg + {{56{cur_byte[7]}}, cur_byte};
                end
                byte_idx_next = byte_idx_reg + 3'd1;
            end
            lphm_pkg::S_REDUCE:
            begin
                // restoring remainder by SLOTS, MSB first, 4 bits per cycle
                for (int i = 0; i < 4; i++)
                begin
                    r = {r[RW-2:0], hash_reg[63-i]};
                    if (r >= SLOTS_R)
                    begin
                        r = r - SLOTS_R;
                    end
                end
                rem_next  = r;
                hash_next = hash_reg << lphm_pkg::RED_BITS;
                grp_next  = grp_reg + 4'd1;
            end
            lphm_pkg::S_PREP:
            begin
                addr_next = rem_reg[AW-1:0];
                cnt_next  = '0;
            end
            lphm_pkg::S_PROBE:
            begin
                addr_next = addr_inc;
                cnt_next  = cnt_reg + AW'(1);
                if (is_add)
                begin
                    if (!is_live)
                    begin
                        status_next = lphm_pkg::ST_OK;
                        live_next   = live_reg + LW'(1);
                    end
                    else if (key_eq)
                    begin
                        status_next = lphm_pkg::ST_DUP;
                    end
                    else
                    begin
                        status_next = lphm_pkg::ST_FULL;
                    end
                end
                else if (is_live && key_eq)
                begin
                    status_next = lphm_pkg::ST_OK;
                    if (mode_reg == lphm_pkg::MODE_GET)
                    begin
                        vout_next = ram_rdata.value;
                    end
                    else
                    begin
                        live_next = live_reg - LW'(1);
                    end
                end
                else
                begin
                    status_next = lphm_pkg::ST_NOTFOUND;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lphm_pkg::S_CLEAR;
            cnt_reg   <= '0;
            live_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        hash_reg     <= hash_next;
        byte_idx_reg <= byte_idx_next;
        grp_reg      <= grp_next;
        rem_reg      <= rem_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        vout_reg     <= vout_next;
    end

    assign status    = status_reg;
    assign value_out = vout_reg;

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= SLOTS_L)
        else $error("live count above table size");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == lphm_pkg::S_CLEAR || state_reg == lphm_pkg::S_PROBE))
        else $error("slot RAM written outside clear or probe");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");

    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && value_out != 64'd0) |-> status == lphm_pkg::ST_OK)
        else $error("value returned with failing status");
`endif

endmodule

### rtl/lphm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lphm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_map_core: directed and random add/get/remove items,
// each reply checked against a slot table kept inside the bench.
// Depends on lphm_pkg and the core RTL; reads no files.
module testbench;
    import lphm_pkg::*;

    localparam int SLOTS     = 64;
    localparam int POOL_SIZE = 96;
    // mode 3 has no operation behind it; the core answers not found
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [63:0] value_out;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] value;
    logic        done;
    logic [2:0]  status;
    logic [63:0] value_out;

    linear_probe_hash_map_core #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .key(key),
        .value(value),
        .done(done),
        .status(status),
        .value_out(value_out)
    );

    // Bench copy of the slot table. Updated at the edge an item is accepted, so
    // the reply it predicts is queued well before the core can show it.
    mark_t       map_mark [SLOTS];
    logic [63:0] map_key [SLOTS];
    logic [63:0] map_value [SLOTS];
    int unsigned map_live;

    reply_t      pending_replies[$];
    reply_t      want;
    logic [63:0] key_pool [POOL_SIZE];

    int unsigned idle_pct;
    int unsigned errors = 0;
    int unsigned replies_seen = 0;
    int unsigned mode_count [4];
    int unsigned status_count [5];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Text is up to 8 bytes, first byte low; everything after the first NUL is dropped.
    function automatic logic [63:0] trim_text(input logic [63:0] t);
        logic [63:0] r;
        r = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (t[8*b +: 8] == 8'h00)
                break;
            r[8*b +: 8] = t[8*b +: 8];
        end
        return r;
    endfunction

    // djb2 over the key bytes, each byte sign-extended, 64-bit wrap, then mod SLOTS.
    function automatic int unsigned home_slot(input logic [63:0] k);
        logic [63:0] h;
        h = HASH_SEED;
        for (int b = 0; b < 8; b++)
        begin
            if (k[8*b +: 8] == 8'h00)
                break;
            h = (h << 5) + h + {{56{k[8*b+7]}}, k[8*b +: 8]};
        end
        return 32'(h % 64'(SLOTS));
    endfunction

    // Apply one request to the bench table and return the reply it must produce.
    function automatic reply_t run_map_request(input logic [1:0] m, input logic [63:0] k_in,
                                               input logic [63:0] v_in);
        logic [63:0] k;
        logic [63:0] v;
        int unsigned idx;
        reply_t      r;
        k = trim_text(k_in);
        v = trim_text(v_in);
        idx = home_slot(k);
        r.status = ST_NOTFOUND;
        r.value_out = '0;
        case (m)
            MODE_ADD:
            begin
                if (map_live >= SLOTS)
                    r.status = ST_FULL;
                else if (v[7:0] == 8'h00)
                    r.status = ST_EMPTYVAL;
                else
                begin
                    r.status = ST_FULL;
                    // first non-live slot wins; a live copy further on is never seen
                    for (int n = 0; n < SLOTS; n++)
                    begin
                        if (map_mark[idx] != MARK_LIVE)
                        begin
                            map_mark[idx] = MARK_LIVE;
                            map_key[idx] = k;
                            map_value[idx] = v;
                            map_live++;
                            r.status = ST_OK;
                            break;
                        end
                        if (map_key[idx] == k)
                        begin
                            r.status = ST_DUP;
                            break;
                        end
                        idx = (idx + 1) % SLOTS;
                    end
                end
            end
            MODE_GET, MODE_REMOVE:
            begin
                // a home slot that is not live ends the search at once
                if (map_mark[idx] == MARK_LIVE)
                begin
                    for (int n = 0; n < SLOTS; n++)
                    begin
                        if (map_mark[idx] == MARK_LIVE && map_key[idx] == k)
                        begin
                            if (m == MODE_GET)
                                r.value_out = map_value[idx];
                            else
                            begin
                                map_mark[idx] = MARK_DELETED;
                                if (map_live > 0)
                                    map_live--;
                            end
                            r.status = ST_OK;
                            break;
                        end
                        idx = (idx + 1) % SLOTS;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] random_text(input int unsigned len);
        logic [63:0] t;
        t = '0;
        for (int b = 0; b < len; b++)
            t[8*b +: 8] = 8'($urandom_range(255, 1));
        return t;
    endfunction

    // Fill the bytes after the first NUL with junk; they must not change anything.
    function automatic logic [63:0] junk_after_nul(input logic [63:0] t);
        logic [63:0] r;
        int          nul;
        r = t;
        nul = 8;
        for (int b = 7; b >= 0; b--)
            if (t[8*b +: 8] == 8'h00)
                nul = b;
        for (int b = nul + 1; b < 8; b++)
            r[8*b +: 8] = 8'($urandom);
        return r;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            v = '0;
        else if (roll < 8)
            v = junk_after_nul('0);
        else if (roll < 14)
            v = {$urandom, $urandom};
        else
            v = random_text($urandom_range(8, 1));
        if ($urandom_range(3) == 0)
            v = junk_after_nul(v);
        return v;
    endfunction

    // Key choice: a key now live in the table (stored_pct), a pool key, or raw noise.
    function automatic logic [63:0] pick_key(input int unsigned stored_pct);
        logic [63:0] k;
        int unsigned roll;
        int unsigned s;
        roll = $urandom_range(99);
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll < stored_pct)
        begin
            s = $urandom_range(SLOTS - 1);
            for (int n = 0; n < SLOTS; n++)
            begin
                if (map_mark[(s + n) % SLOTS] == MARK_LIVE)
                begin
                    k = map_key[(s + n) % SLOTS];
                    break;
                end
            end
        end
        else if (roll >= 92)
            k = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            k = junk_after_nul(k);
        return k;
    endfunction

    // Two-byte key whose home slot is the one given.
    function automatic logic [63:0] key_in_slot(input int unsigned slot, input logic [63:0] other);
        logic [63:0] k;
        do
            k = random_text(2);
        while (home_slot(k) != slot || k == other);
        return k;
    endfunction

    // One item: optional idle gap, then hold start until an edge sees busy low.
    // start drops at the accept edge; the next item can raise it again while the
    // core is still busy with this one.
    task automatic send_item(input logic [1:0] m, input logic [63:0] k, input logic [63:0] v);
        reply_t r;
        @(posedge clk);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        mode  <= m;
        key   <= k;
        value <= v;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        start <= 1'b0;
        r = run_map_request(m, k, v);
        pending_replies.push_back(r);
        mode_count[m]++;
        status_count[int'(r.status)]++;
    endtask

    task automatic wait_for_replies();
        int unsigned guard;
        guard = 0;
        while (pending_replies.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // Empty table, the unused mode, duplicates, junk after NUL, the empty key,
    // an all-0xFF key (sign extension in the hash) and the empty value refusal.
    task automatic test_basic_requests();
        logic [63:0] a_key;
        a_key = 64'h61;
        idle_pct = 0;
        send_item(MODE_GET, a_key, '0);
        send_item(MODE_REMOVE, a_key, '0);
        send_item(MODE_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(MODE_ADD, a_key, '1);
        send_item(MODE_GET, a_key, {$urandom, $urandom});
        send_item(MODE_ADD, a_key, 64'h62);
        send_item(MODE_ADD, 64'h0000_007A_7978_0061, 64'h63);
        send_item(MODE_GET, 64'hFFFF_FF00_0061 | 64'h0000_0000_0000_0061, '0);
        send_item(MODE_ADD, '1, 64'h76);
        send_item(MODE_GET, '1, '0);
        send_item(MODE_ADD, '0, 64'h65);
        send_item(MODE_GET, 64'hDEAD_BEEF_CAFE_BA00, '0);
        send_item(MODE_ADD, 64'h62, '0);
        send_item(MODE_ADD, 64'h62, 64'hFFFF_FFFF_FFFF_FF00);
        send_item(MODE_REMOVE, '1, '0);
        send_item(MODE_GET, '1, '0);
    endtask

    // Two keys homed on the last slot: wrap to slot 0, a deleted home slot that
    // hides a live key, and a re-add that lands in front of its own old copy.
    task automatic test_collision_chain();
        logic [63:0] first_key;
        logic [63:0] second_key;
        first_key = key_in_slot(SLOTS - 1, '0);
        second_key = key_in_slot(SLOTS - 1, first_key);
        idle_pct = 0;
        send_item(MODE_ADD, first_key, random_text(8));
        send_item(MODE_ADD, second_key, random_text(8));
        send_item(MODE_GET, second_key, '0);
        send_item(MODE_REMOVE, first_key, '0);
        send_item(MODE_GET, second_key, '0);
        send_item(MODE_REMOVE, second_key, '0);
        send_item(MODE_ADD, second_key, random_text(5));
        send_item(MODE_GET, second_key, '0);
        send_item(MODE_REMOVE, second_key, '0);
        send_item(MODE_REMOVE, second_key, '0);
    endtask

    // Fill the table to the top, knock on it while full, then empty most of it.
    task automatic test_fill_and_drain(input int unsigned idle);
        int unsigned guard;
        idle_pct = idle;
        guard = 0;
        while (map_live < SLOTS && guard < 400)
        begin
            send_item(MODE_ADD, pick_key(0), random_value());
            guard++;
        end
        // full wins over an empty value and over a duplicate
        send_item(MODE_ADD, {$urandom, $urandom}, random_text(3));
        send_item(MODE_ADD, pick_key(100), '0);
        send_item(MODE_ADD, pick_key(100), random_text(8));
        repeat (3)
            send_item(MODE_GET, pick_key(100), '0);
        // keys stranded behind a deleted home slot cannot be removed, hence the guard
        guard = 0;
        while (map_live > 0 && guard < 150)
        begin
            if ($urandom_range(99) < 85)
                send_item(MODE_REMOVE, pick_key(90), '0);
            else
                send_item(MODE_GET, pick_key(50), '0);
            guard++;
        end
    endtask

    task automatic test_mixed_traffic(input int unsigned count, input int unsigned idle);
        int unsigned roll;
        idle_pct = idle;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < 38)
                send_item(MODE_ADD, pick_key(15), random_value());
            else if (roll < 68)
                send_item(MODE_GET, pick_key(55), {$urandom, $urandom});
            else if (roll < 96)
                send_item(MODE_REMOVE, pick_key(55), {$urandom, $urandom});
            else
                send_item(MODE_UNUSED, pick_key(30), {$urandom, $urandom});
        end
    endtask

    // Reply checker: one reply per item, in order, never held off.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with no item pending: status %0d value_out %h",
                         $time, status, value_out);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d (%s) actual %0d",
                             $time, want.status, want.status.name(), status);
                end
                if (value_out !== want.value_out)
                begin
                    errors++;
                    $display("%0t: value_out mismatch: expected %h actual %h",
                             $time, want.value_out, value_out);
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        mode  <= MODE_ADD;
        key   <= '0;
        value <= '0;
        idle_pct = 0;
        map_live = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            map_mark[i] = MARK_EMPTY;
            map_key[i] = '0;
            map_value[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            mode_count[i] = 0;
        for (int i = 0; i < 5; i++)
            status_count[i] = 0;
        // pool is larger than the table so random adds can fill it; entry 0 is the empty key
        key_pool[0] = '0;
        for (int i = 1; i < POOL_SIZE; i++)
            key_pool[i] = random_text($urandom_range(8, 1));

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        // the clearing sweep after reset shows up as busy; send_item waits it out

        test_basic_requests();
        test_collision_chain();
        test_fill_and_drain(0);
        test_mixed_traffic(470, 0);
        // let the core run dry before the idle-heavy stretch
        wait_for_replies();
        test_mixed_traffic(470, 82);
        test_fill_and_drain(82);
        test_mixed_traffic(470, 24);

        wait_for_replies();
        repeat (SLOTS + 40)
            @(posedge clk);
        if (pending_replies.size() != 0)
            $display("%0t: %0d replies never arrived", $time, pending_replies.size());
        $display("Ran %0d adds, %0d gets, %0d removes, %0d unused-mode items;",
                 mode_count[MODE_ADD], mode_count[MODE_GET], mode_count[MODE_REMOVE],
                 mode_count[MODE_UNUSED]);
        $display("%0d replies seen: %0d ok, %0d dup, %0d full, %0d empty value, %0d not found.",
                 replies_seen, status_count[ST_OK], status_count[ST_DUP], status_count[ST_FULL],
                 status_count[ST_EMPTYVAL], status_count[ST_NOTFOUND]);
        if (errors == 0 && pending_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run of about 2000 items plus gaps.
    initial
    begin
        #20_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("FAILURE");
        $finish;
    end

endmodule
